>>> rtl/core/led_pattern_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lps same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lps next-cycle check failed");

`endif

>>> rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Pattern codes, opcodes, timing constants, state type and selection rule.
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int OPCODE_W  = 2;
   localparam int PATTERN_W = 3;
   localparam int PHASE_W   = 3;
   localparam int ELAPSED_W = 10;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RAW    = 2'd2;

   // pattern codes
   localparam logic [PATTERN_W-1:0] PAT_OFF   = 3'd0;
   localparam logic [PATTERN_W-1:0] PAT_ON    = 3'd1;
   localparam logic [PATTERN_W-1:0] PAT_SLOW  = 3'd2;
   localparam logic [PATTERN_W-1:0] PAT_RAPID = 3'd3;
   localparam logic [PATTERN_W-1:0] PAT_SOLID = 3'd4;
   localparam logic [PATTERN_W-1:0] PAT_LONG  = 3'd5;
   localparam logic [PATTERN_W-1:0] PAT_TWO   = 3'd6;
   localparam logic [PATTERN_W-1:0] PAT_HEART = 3'd7;

   // two-short-blink steps
   localparam logic [PHASE_W-1:0] TWO_FIRST_ON  = 3'd1;
   localparam logic [PHASE_W-1:0] TWO_FIRST_OFF = 3'd2;
   localparam logic [PHASE_W-1:0] TWO_SECOND_ON = 3'd3;
   localparam logic [PHASE_W-1:0] TWO_DONE      = 3'd4;

   // heartbeat phases
   localparam logic [PHASE_W-1:0] HB_BEAT1 = 3'd0;
   localparam logic [PHASE_W-1:0] HB_GAP   = 3'd1;
   localparam logic [PHASE_W-1:0] HB_BEAT2 = 3'd2;
   localparam logic [PHASE_W-1:0] HB_REST  = 3'd3;

   // timing in milliseconds
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 10'd1023;
   localparam logic [ELAPSED_W-1:0] SLOW_MS     = 10'd500;
   localparam logic [ELAPSED_W-1:0] RAPID_MS    = 10'd100;
   localparam logic [ELAPSED_W-1:0] SOLID_MS    = 10'd1000;
   localparam logic [ELAPSED_W-1:0] LONG_MS     = 10'd800;
   localparam logic [ELAPSED_W-1:0] TWO_STEP_MS = 10'd50;
   localparam logic [ELAPSED_W-1:0] HB_BEAT_MS  = 10'd80;
   localparam logic [ELAPSED_W-1:0] HB_GAP_MS   = 10'd100;
   localparam logic [ELAPSED_W-1:0] HB_REST_MS  = 10'd740;

   typedef struct packed {
      logic [PATTERN_W-1:0] cur_pattern;
      logic [PATTERN_W-1:0] prev_pattern;
      logic [PHASE_W-1:0]   phase_step;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic                 led_on;
   } lps_state_type;

   // Switch to pattern p; re-selecting a running pattern is dropped unless
   // it is a one-shot, which restarts.
   function automatic lps_state_type select_pattern(lps_state_type s,
                                                    logic [PATTERN_W-1:0] p);
      lps_state_type r;
      r = s;
      if (!(s.cur_pattern == p && !(p inside {PAT_SOLID, PAT_LONG, PAT_TWO}))) begin
         r.prev_pattern = s.cur_pattern;
         r.cur_pattern  = p;
         r.phase_step   = '0;
         r.elapsed_ms   = '0;
         if (p inside {PAT_SOLID, PAT_LONG, PAT_ON}) begin
            r.led_on = 1'b1;
         end else if (p == PAT_OFF) begin
            r.led_on = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/led_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer top level
// Tick / select / raw-drive words in, one pin level and active pattern out.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+-----------
//   request  | req_valid, req_stall, req_opcode,       | in
//            | req_pattern, req_raw_level              |
//   response | rsp_valid, rsp_stall, rsp_pin_level,    | out
//            | rsp_active_pattern                      |
//   csr      | csr_write_en, csr_write_data            | in
//
// Throughput is one word per cycle while the response is not stalled; a word
// passes the input register, then the pattern update, then the result register.
// Reset (synchronous, active high) empties both stages, clears the pattern
// state and sets active_low to 1.
// A stalled response holds the result register and the sequencer state; the
// input register then fills and raises req_stall in the same cycle.
//
`include "led_pattern_sequencer_top_macros.svh"

module led_pattern_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lps_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [lps_pkg::PATTERN_W-1:0]  req_pattern,
   input  logic                           req_raw_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pin_level,
   output logic [lps_pkg::PATTERN_W-1:0]  rsp_active_pattern,
   input  logic                           csr_write_en,
   input  logic                           csr_write_data
);
   import lps_pkg::*;

   // input stage
   logic                 in_valid_ff;
   logic [OPCODE_W-1:0]  in_opcode_ff;
   logic [PATTERN_W-1:0] in_pattern_ff;
   logic                 in_raw_ff;

   // result stage
   logic                 out_valid_ff;
   logic                 out_pin_ff;
   logic [PATTERN_W-1:0] out_pattern_ff;

   // sequencer state and config
   lps_state_type        state_ff;
   lps_state_type        state_in;
   logic                 active_low_ff;

   logic                 advance;
   logic [ELAPSED_W-1:0] elapsed_inc;

   // Move the input word into the result stage whenever the result slot is
   // free or is being taken this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_opcode_ff  <= req_opcode;
         in_pattern_ff <= req_pattern;
         in_raw_ff     <= req_raw_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= 1'b1;
      end else if (csr_write_en) begin
         active_low_ff <= csr_write_data;
      end
   end

   // Saturating millisecond count for the tick path.
   assign elapsed_inc = (state_ff.elapsed_ms == ELAPSED_MAX) ?
                        state_ff.elapsed_ms : state_ff.elapsed_ms + 10'd1;

   // Apply one word to the sequencer state.
   always_comb begin
      state_in = state_ff;
      case (in_opcode_ff)
         OP_TICK: begin
            state_in.elapsed_ms = elapsed_inc;
            case (state_ff.cur_pattern)
               PAT_OFF: begin
                  state_in.led_on = 1'b0;
               end
               PAT_ON: begin
                  state_in.led_on = 1'b1;
               end
               PAT_SLOW, PAT_RAPID: begin
                  // toggle every half period
                  if (elapsed_inc >= ((state_ff.cur_pattern == PAT_SLOW) ?
                                      SLOW_MS : RAPID_MS)) begin
                     state_in.elapsed_ms = '0;
                     state_in.phase_step = (state_ff.phase_step != '0) ?
                                           3'd0 : 3'd1;
                     state_in.led_on     = (state_ff.phase_step == '0);
                  end
               end
               PAT_SOLID, PAT_LONG: begin
                  // one-shot end: revert, slow blink falls back to off
                  if (elapsed_inc >= ((state_ff.cur_pattern == PAT_SOLID) ?
                                      SOLID_MS : LONG_MS)) begin
                     state_in.led_on = 1'b0;
                     state_in = select_pattern(state_in,
                        (state_ff.prev_pattern == PAT_SLOW) ? PAT_OFF :
                        state_ff.prev_pattern);
                  end
               end
               PAT_TWO: begin
                  if (elapsed_inc >= TWO_STEP_MS) begin
                     state_in.elapsed_ms = '0;
                     state_in.phase_step = state_ff.phase_step + 3'd1;
                     case (state_in.phase_step)
                        TWO_FIRST_ON:  state_in.led_on = 1'b1;
                        TWO_FIRST_OFF: state_in.led_on = 1'b0;
                        TWO_SECOND_ON: state_in.led_on = 1'b1;
                        TWO_DONE: begin
                           state_in.led_on = 1'b0;
                           state_in = select_pattern(state_in,
                                                     state_ff.prev_pattern);
                        end
                        default: ;
                     endcase
                  end
               end
               default: begin
                  // heartbeat: beat, gap, beat, rest
                  case (state_ff.phase_step)
                     HB_BEAT1: begin
                        state_in.led_on = 1'b1;
                        if (elapsed_inc >= HB_BEAT_MS) begin
                           state_in.phase_step = HB_GAP;
                           state_in.elapsed_ms = '0;
                        end
                     end
                     HB_GAP: begin
                        state_in.led_on = 1'b0;
                        if (elapsed_inc >= HB_GAP_MS) begin
                           state_in.phase_step = HB_BEAT2;
                           state_in.elapsed_ms = '0;
                        end
                     end
                     HB_BEAT2: begin
                        state_in.led_on = 1'b1;
                        if (elapsed_inc >= HB_BEAT_MS) begin
                           state_in.phase_step = HB_REST;
                           state_in.elapsed_ms = '0;
                        end
                     end
                     HB_REST: begin
                        state_in.led_on = 1'b0;
                        if (elapsed_inc >= HB_REST_MS) begin
                           state_in.phase_step = HB_BEAT1;
                           state_in.elapsed_ms = '0;
                        end
                     end
                     default: ;
                  endcase
               end
            endcase
         end
         OP_SELECT: begin
            state_in = select_pattern(state_ff, in_pattern_ff);
         end
         OP_RAW: begin
            state_in.led_on = in_raw_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pin_ff     <= state_in.led_on ^ active_low_ff;
         out_pattern_ff <= state_in.cur_pattern;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pin_level      = out_pin_ff;
   assign rsp_active_pattern = out_pattern_ff;

   // Hold the sequencer state while the result waits.
   `LPS_ASSERT_NEXT(a_state_hold, clock, reset, out_valid_ff && rsp_stall, $stable(state_ff))
   // Back-pressure only with a word in the input stage.
   `LPS_ASSERT_SAME(a_stall_src, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   // Heartbeat never leaves its four phases.
   `LPS_ASSERT_SAME(a_hb_phase, clock, reset, state_ff.cur_pattern == PAT_HEART, state_ff.phase_step <= HB_REST)
   // Two short blinks never rests on its final step.
   `LPS_ASSERT_SAME(a_two_phase, clock, reset, state_ff.cur_pattern == PAT_TWO, state_ff.phase_step < TWO_DONE)

endmodule
